/* hdl/rtd_pkg.sv */
// Shared types and constants for the rpm tachometer with decimal digits.
`timescale 1ns / 1ps

package rtd_pkg;

  localparam int COUNT_WIDTH_DEF = 10;
  localparam int KEY_W           = 8;
  localparam int RPM_W           = 16;
  localparam int DIGIT_W         = 6;
  localparam int OUT_W           = RPM_W + 4 * DIGIT_W;

  localparam logic [KEY_W-1:0]   KEY_LIMIT  = 8'd64;
  localparam logic [RPM_W-1:0]   RPM_HOLD   = 16'd10000;
  localparam logic [DIGIT_W-1:0] ASCII_ZERO = 6'd48;
  localparam logic [DIGIT_W-1:0] ASCII_NINE = 6'd57;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_TICK   = 1'b1
  } kind_t;

  typedef struct packed {
    logic             valid;
    logic [RPM_W-1:0] rpm;
  } rpm_link_t;

endpackage

/* hdl/rtd_core.sv */
// Input register, pulse counter and smoothed rpm computation.
`timescale 1ns / 1ps

module rtd_core import rtd_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [KEY_W-1:0] in_tdata,   // key_code
  input  logic             in_tuser,   // kind
  output rpm_link_t        link_o,
  input  logic             link_ready
);

  localparam int PROD_W = COUNT_WIDTH + 6;
  localparam int SUM_W  = RPM_W + 1;

  logic                   s1_v_r, s1_v_nxt;
  kind_t                  s1_kind_r, s1_kind_nxt;
  logic [KEY_W-1:0]       s1_key_r, s1_key_nxt;
  logic [KEY_W-1:0]       prev_key_r, prev_key_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [RPM_W-1:0]       prev_rpm_r, prev_rpm_nxt;

  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  sum;
  logic [RPM_W-1:0]  rpm_calc;
  logic              emit;
  logic              consume;
  logic              pulse;

  // pulses * 60 as (x << 6) - (x << 2)
  assign prod     = {cnt_r, 6'b0} - {4'b0, cnt_r, 2'b0};
  assign sum      = SUM_W'(prod) + SUM_W'(prev_rpm_r);
  assign rpm_calc = sum[SUM_W-1:1];

  assign emit    = s1_v_r && (s1_kind_r == KIND_TICK) && (rpm_calc != prev_rpm_r);
  assign consume = s1_v_r && (!emit || link_ready);

  assign in_tready   = !s1_v_r || consume;
  assign link_o.valid = emit;
  assign link_o.rpm   = rpm_calc;

  assign pulse = (s1_key_r != '0) && (s1_key_r < KEY_LIMIT) && (cnt_r != '1);

  always_comb begin
    s1_v_nxt     = s1_v_r;
    s1_kind_nxt  = s1_kind_r;
    s1_key_nxt   = s1_key_r;
    prev_key_nxt = prev_key_r;
    cnt_nxt      = cnt_r;
    prev_rpm_nxt = prev_rpm_r;
    if (consume) begin
      s1_v_nxt = 1'b0;
      if (s1_kind_r == KIND_TICK) begin
        cnt_nxt = '0;
        if (emit) begin
          prev_rpm_nxt = rpm_calc;
        end
      end else if (s1_key_r != prev_key_r) begin
        prev_key_nxt = s1_key_r;
        if (pulse) begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
    end
    if (in_tvalid && in_tready) begin
      s1_v_nxt    = 1'b1;
      s1_kind_nxt = kind_t'(in_tuser);
      s1_key_nxt  = in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    s1_kind_r <= s1_kind_nxt;
    s1_key_r  <= s1_key_nxt;
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      prev_key_r <= '0;
      cnt_r      <= '0;
      prev_rpm_r <= '0;
    end else begin
      s1_v_r     <= s1_v_nxt;
      prev_key_r <= prev_key_nxt;
      cnt_r      <= cnt_nxt;
      prev_rpm_r <= prev_rpm_nxt;
    end
  end

`ifndef SYNTHESIS
  a_tick_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (consume && s1_kind_r == KIND_TICK) |=> (cnt_r == '0))
    else $error("pulse count not cleared by tick");

  a_same_key_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    (consume && s1_kind_r == KIND_SAMPLE && s1_key_r == prev_key_r) |=> $stable(cnt_r))
    else $error("pulse counted without key change");

  a_link_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (link_o.valid && !link_ready) |=> (link_o.valid && $stable(link_o.rpm)))
    else $error("stalled rpm changed before transfer");
`endif

endmodule

/* hdl/rtd_digits.sv */
// Decimal digit pipeline, held digits and result register.
`timescale 1ns / 1ps

module rtd_digits import rtd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  rpm_link_t        link_i,
  output logic             link_ready_o,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // rpm, thousands, hundreds, tens, ones
);

  logic               a_v_r, a_v_nxt;
  logic [RPM_W-1:0]   a_rpm_r, a_rpm_nxt;
  logic               b_v_r, b_v_nxt;
  logic [RPM_W-1:0]   b_rpm_r, b_rpm_nxt;
  logic               b_hold_r, b_hold_nxt;
  logic [3:0]         b_thou_r, b_thou_nxt;
  logic [9:0]         b_rem_r, b_rem_nxt;
  logic               out_v_r, out_v_nxt;
  logic [OUT_W-1:0]   out_data_r, out_data_nxt;
  logic [DIGIT_W-1:0] shown_r [4];
  logic [DIGIT_W-1:0] shown_nxt [4];

  logic out_free, b_free, a_free;

  logic [3:0]  thou;
  logic [13:0] thou_sub;
  logic [3:0]  hun, tens, ones;
  logic [9:0]  hun_sub;
  logic [6:0]  rem100;
  logic [6:0]  tens_sub;
  logic [DIGIT_W-1:0] calc [4];

  assign out_free     = !out_v_r || out_tready;
  assign b_free       = !b_v_r || out_free;
  assign a_free       = !a_v_r || b_free;
  assign link_ready_o = a_free;
  assign out_tvalid   = out_v_r;
  assign out_tdata    = out_data_r;

  always_comb begin
    thou     = '0;
    thou_sub = '0;
    for (int k = 1; k <= 9; k++) begin
      if (a_rpm_r[13:0] >= 14'(k * 1000)) begin
        thou     = 4'(k);
        thou_sub = 14'(k * 1000);
      end
    end
  end

  always_comb begin
    hun     = '0;
    hun_sub = '0;
    for (int k = 1; k <= 9; k++) begin
      if (b_rem_r >= 10'(k * 100)) begin
        hun     = 4'(k);
        hun_sub = 10'(k * 100);
      end
    end
    rem100   = 7'(b_rem_r - hun_sub);
    tens     = '0;
    tens_sub = '0;
    for (int k = 1; k <= 9; k++) begin
      if (rem100 >= 7'(k * 10)) begin
        tens     = 4'(k);
        tens_sub = 7'(k * 10);
      end
    end
    ones    = 4'(rem100 - tens_sub);
    calc[0] = ASCII_ZERO + DIGIT_W'(b_thou_r);
    calc[1] = ASCII_ZERO + DIGIT_W'(hun);
    calc[2] = ASCII_ZERO + DIGIT_W'(tens);
    calc[3] = ASCII_ZERO + DIGIT_W'(ones);
  end

  always_comb begin
    a_v_nxt      = a_v_r;
    a_rpm_nxt    = a_rpm_r;
    b_v_nxt      = b_v_r;
    b_rpm_nxt    = b_rpm_r;
    b_hold_nxt   = b_hold_r;
    b_thou_nxt   = b_thou_r;
    b_rem_nxt    = b_rem_r;
    out_v_nxt    = out_v_r;
    out_data_nxt = out_data_r;
    shown_nxt    = shown_r;
    if (a_free) begin
      a_v_nxt = link_i.valid;
      if (link_i.valid) begin
        a_rpm_nxt = link_i.rpm;
      end
    end
    if (b_free) begin
      b_v_nxt = a_v_r;
      if (a_v_r) begin
        b_rpm_nxt  = a_rpm_r;
        b_hold_nxt = (a_rpm_r >= RPM_HOLD);
        b_thou_nxt = thou;
        b_rem_nxt  = 10'(a_rpm_r[13:0] - thou_sub);
      end
    end
    if (out_free) begin
      out_v_nxt = b_v_r;
      if (b_v_r) begin
        if (!b_hold_r) begin
          shown_nxt = calc;
        end
        out_data_nxt = {shown_nxt[3], shown_nxt[2], shown_nxt[1], shown_nxt[0], b_rpm_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    a_rpm_r    <= a_rpm_nxt;
    b_rpm_r    <= b_rpm_nxt;
    b_hold_r   <= b_hold_nxt;
    b_thou_r   <= b_thou_nxt;
    b_rem_r    <= b_rem_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
      out_v_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        shown_r[i] <= ASCII_ZERO;
      end
    end else begin
      a_v_r   <= a_v_nxt;
      b_v_r   <= b_v_nxt;
      out_v_r <= out_v_nxt;
      shown_r <= shown_nxt;
    end
  end

`ifndef SYNTHESIS
  a_digits_ascii: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_data_r[21:16] >= ASCII_ZERO && out_data_r[21:16] <= ASCII_NINE &&
                 out_data_r[27:22] >= ASCII_ZERO && out_data_r[27:22] <= ASCII_NINE &&
                 out_data_r[33:28] >= ASCII_ZERO && out_data_r[33:28] <= ASCII_NINE &&
                 out_data_r[39:34] >= ASCII_ZERO && out_data_r[39:34] <= ASCII_NINE))
    else $error("result digit outside ASCII 0..9");

  a_split_range: assert property (@(posedge clk) disable iff (!rst_n)
    (b_v_r && !b_hold_r) |-> (b_thou_r <= 4'd9 && b_rem_r < 10'd1000))
    else $error("thousands split out of range");

  a_stage_a_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (a_v_r && !b_free) |=> (a_v_r && $stable(a_rpm_r)))
    else $error("stalled rpm lost in digit pipeline");
`endif

endmodule

/* hdl/rpm_tachometer_with_decimal_digits.sv */
// Top level of the rpm tachometer with four ASCII decimal digits.
// A tick that changes rpm passes the core input register and digit registers a, b, out.
// Throughput: one input per cycle unless a result stalls; only rpm changes give results.
// Output register and three pipeline registers decouple the two sides under backpressure.
// Reset (synchronous, rst_n low): pipeline empty, key, pulse count and rpm zero,
// held digits all ASCII '0'.
`timescale 1ns / 1ps

module rpm_tachometer_with_decimal_digits import rtd_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [KEY_W-1:0] in_tdata,   // key_code
  input  logic             in_tuser,   // kind
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // rpm, digit_thousands, digit_hundreds, digit_tens,
                                       // digit_ones
);

  rpm_link_t link;
  logic      link_ready;

  rtd_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .link_o     (link),
    .link_ready (link_ready)
  );

  rtd_digits u_digits (
    .clk          (clk),
    .rst_n        (rst_n),
    .link_i       (link),
    .link_ready_o (link_ready),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata)
  );

endmodule

/* tb/sv/tb_top.sv */
// Testbench for the rpm tachometer: stream driver, monitor and scoreboard.
`timescale 1ns / 1ps

module tb_top;
  import rtd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_ITEMS  = 330;
  localparam int SAT_PULSES  = 1030;
  localparam logic [9:0] PULSE_FULL = '1;

  typedef struct {
    kind_t      kind;
    logic [7:0] code;
  } key_item_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] d_on;
    logic [DIGIT_W-1:0] d_te;
    logic [DIGIT_W-1:0] d_hu;
    logic [DIGIT_W-1:0] d_th;
    logic [RPM_W-1:0]   rpm;
  } reading_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [KEY_W-1:0] in_tdata = '0;
  logic             in_tuser = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  rpm_tachometer_with_decimal_digits dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #10 clk = ~clk;

  key_item_t  pending_items[$];
  reading_t   expected_readings[$];
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  logic       in_xfer = 1'b0;
  int         total_queued = 0;
  int         items_in = 0;
  int         readings_checked = 0;
  int         high_rpm_seen = 0;
  int         full_count_ticks = 0;
  int         err_count = 0;
  int         cycles = 0;

  // tachometer state mirrored by the scoreboard
  logic [7:0]         key_q = '0;
  logic [9:0]         pulse_q = '0;
  logic [RPM_W-1:0]   rpm_q = '0;
  logic [DIGIT_W-1:0] dig_q[4] = '{ASCII_ZERO, ASCII_ZERO, ASCII_ZERO, ASCII_ZERO};

  // generator's view of the key stream
  logic [7:0] gen_key = '0;
  int         last_pulses = 0;

  task automatic report_mismatch(string field, int want, int got);
    $display("tb_top: mismatch on %s: expected %0d, got %0d (t=%0t)", field, want, got, $time);
    err_count++;
  endtask

  task automatic tachometer_step(kind_t kind, logic [7:0] code);
    logic [31:0] r;
    reading_t    rd;
    if (kind == KIND_SAMPLE) begin
      if (code != key_q) begin
        key_q = code;
        if (code != 8'd0 && code < KEY_LIMIT && pulse_q != PULSE_FULL) pulse_q++;
      end
    end else begin
      if (pulse_q == PULSE_FULL) full_count_ticks++;
      r = (32'(pulse_q) * 60 + 32'(rpm_q)) / 2;
      pulse_q = '0;
      if (r[15:0] != rpm_q) begin
        if (r < 32'(RPM_HOLD)) begin
          dig_q[0] = ASCII_ZERO + DIGIT_W'((r / 1000) % 10);
          dig_q[1] = ASCII_ZERO + DIGIT_W'((r / 100) % 10);
          dig_q[2] = ASCII_ZERO + DIGIT_W'((r / 10) % 10);
          dig_q[3] = ASCII_ZERO + DIGIT_W'(r % 10);
        end
        rpm_q = r[15:0];
        rd.rpm  = r[15:0];
        rd.d_th = dig_q[0];
        rd.d_hu = dig_q[1];
        rd.d_te = dig_q[2];
        rd.d_on = dig_q[3];
        expected_readings.push_back(rd);
      end
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      if (!in_tvalid || in_xfer) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          key_item_t it;
          it = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= it.code;
          in_tuser  <= it.kind;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    reading_t got, want;
    in_xfer <= in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (got.rpm >= RPM_HOLD) high_rpm_seen++;
        if (expected_readings.size() == 0) begin
          report_mismatch("unexpected reading rpm", 0, got.rpm);
        end else begin
          want = expected_readings.pop_front();
          readings_checked++;
          if (got.rpm != want.rpm)   report_mismatch("rpm", want.rpm, got.rpm);
          if (got.d_th != want.d_th) report_mismatch("digit_thousands", want.d_th, got.d_th);
          if (got.d_hu != want.d_hu) report_mismatch("digit_hundreds", want.d_hu, got.d_hu);
          if (got.d_te != want.d_te) report_mismatch("digit_tens", want.d_te, got.d_te);
          if (got.d_on != want.d_on) report_mismatch("digit_ones", want.d_on, got.d_on);
        end
      end
      if (in_tvalid && in_tready) begin
        tachometer_step(kind_t'(in_tuser), in_tdata);
        items_in++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic push_item(kind_t kind, logic [7:0] code);
    key_item_t it;
    it.kind = kind;
    it.code = code;
    pending_items.push_back(it);
    total_queued++;
    if (kind == KIND_SAMPLE) gen_key = code;
  endtask

  function automatic logic [7:0] pulse_code();
    logic [7:0] c;
    do c = 8'($urandom_range(63, 1)); while (c == gen_key);
    return c;
  endfunction

  // one measurement interval: n samples, then a tick
  task automatic add_interval(int n, bit mixed);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (!mixed || r >= 40) push_item(KIND_SAMPLE, pulse_code());
      else if (r < 15)       push_item(KIND_SAMPLE, 8'd0);
      else if (r < 30)       push_item(KIND_SAMPLE, gen_key);
      else                   push_item(KIND_SAMPLE, 8'($urandom_range(255, 64)));
    end
    push_item(KIND_TICK, 8'($urandom_range(255)));
    last_pulses = n;
  endtask

  task automatic add_random(int count);
    int stop_at, r, n;
    stop_at = total_queued + count;
    while (total_queued < stop_at) begin
      r = $urandom_range(99);
      if (r < 10) begin
        n = $urandom_range(20, 1);
        for (int i = 0; i < n; i++)
          push_item(kind_t'($urandom_range(1)), 8'($urandom_range(255)));
      end else if (r < 18) begin
        add_interval($urandom_range(120, 40), 1'b0);
      end else if (r < 35) begin
        add_interval(last_pulses, 1'b0);
      end else begin
        add_interval($urandom_range(25), 1'b1);
      end
    end
  endtask

  task automatic drain_pending();
    while (pending_items.size() > 0) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 11;
    recv_idle_pct = 72;
    // directed: idle tick, key code boundaries, held key across a tick, decay to zero
    push_item(KIND_TICK,   8'd0);
    push_item(KIND_SAMPLE, 8'd0);
    push_item(KIND_SAMPLE, 8'd1);
    push_item(KIND_SAMPLE, 8'd1);
    push_item(KIND_SAMPLE, 8'd63);
    push_item(KIND_SAMPLE, 8'd64);
    push_item(KIND_SAMPLE, 8'd255);
    push_item(KIND_SAMPLE, 8'd0);
    push_item(KIND_SAMPLE, 8'h2A);
    push_item(KIND_TICK,   8'hFF);
    push_item(KIND_SAMPLE, 8'h2A);
    push_item(KIND_SAMPLE, 8'h15);
    push_item(KIND_SAMPLE, 8'h80);
    push_item(KIND_TICK,   8'h55);
    for (int i = 0; i < 8; i++) push_item(KIND_TICK, 8'hAA);
    add_random(RAND_ITEMS / 3);
    drain_pending();

    send_idle_pct = 72;
    recv_idle_pct = 11;
    add_random(RAND_ITEMS / 3);
    drain_pending();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // saturate the pulse counter, then let the speed decay past the digit hold limit
    add_interval(SAT_PULSES, 1'b0);
    for (int i = 0; i < 4; i++) push_item(KIND_TICK, 8'd0);
    add_random(RAND_ITEMS / 3);

    while (items_in < total_queued || expected_readings.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("tb_top: %0d items sent, %0d readings checked", items_in, readings_checked);
    $display("tb_top: %0d readings at 10000 rpm or more, %0d ticks with a full pulse count",
             high_rpm_seen, full_count_ticks);
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/rtd_pkg.sv
hdl/rtd_core.sv
hdl/rtd_digits.sv
hdl/rpm_tachometer_with_decimal_digits.sv
tb/sv/tb_top.sv
